>>> hw/rtl/cda_pkg.sv
// Shared types, constants and helper functions of the calendar date adjuster.
package cda_pkg;

   localparam int YEAR_BITS = 16;
   localparam int AMOUNT_W  = 16;
   localparam int OP_W      = 3;
   localparam int MONTH_W   = 4;
   localparam int DAY_OUT_W = 5;
   localparam int CUR_YEAR_W = 16;
   // Holds the largest day count before normalization: 31 plus the largest amount.
   localparam int DAY_W     = AMOUNT_W + 1;
   localparam int MSUM_W    = AMOUNT_W + 1;
   localparam int ADD_W     = ((YEAR_BITS > AMOUNT_W) ? YEAR_BITS : AMOUNT_W) + 1;

   localparam logic [YEAR_BITS-1:0] YEAR_MAX   = '1;
   localparam logic [YEAR_BITS-1:0] YEAR_RESET = YEAR_BITS'(2018);
   localparam logic [MONTH_W-1:0]   MONTHS_PER_YEAR = MONTH_W'(12);

   // Four years always hold exactly 48 months and 1461 days, whatever month they start in.
   localparam logic [DAY_W-1:0]     DAYS_PER_QUAD = DAY_W'(1461);
   localparam logic [AMOUNT_W-1:0]  YEARS_PER_QUAD = AMOUNT_W'(4);

   // Division by twelve: quotient = (m * 43691) >> 19, exact for m below 2**17.
   localparam int                   RECIP_SHIFT = 19;
   localparam logic [15:0]          RECIP_12    = 16'd43691;
   localparam int                   QUOT_W      = MSUM_W - 3;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_DAYS   = 3'd0,
      OP_ADD_MONTHS = 3'd1,
      OP_ADD_YEARS  = 3'd2,
      OP_SET_DAY    = 3'd3,
      OP_SET_MONTH  = 3'd4,
      OP_SET_YEAR   = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ADD_DAYS,
      CMD_ADD_MONTHS,
      CMD_ADD_YEARS,
      CMD_SET_DAY,
      CMD_SET_MONTH,
      CMD_SET_YEAR,
      CMD_IGNORE,
      CMD_DIVIDE,
      CMD_APPLY_MONTHS,
      CMD_NORM_STEP
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
      logic       emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic norm_done;
   } dp_status_type;

   localparam logic [DAY_OUT_W-1:0] MONTH_LEN [16] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
   };

   localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);

   function automatic logic [DAY_OUT_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                    input logic [1:0] year_low);
      logic [DAY_OUT_W-1:0] len;
      len = MONTH_LEN[m];
      if (m == FEBRUARY && year_low == 2'b00) begin
         len = DAY_OUT_W'(29);
      end
      return len;
   endfunction

   function automatic logic [YEAR_BITS-1:0] year_sat_add(input logic [YEAR_BITS-1:0] year,
                                                         input logic [AMOUNT_W-1:0] n);
      logic [ADD_W-1:0] sum;
      sum = ADD_W'(year) + ADD_W'(n);
      if (sum >= ADD_W'(YEAR_MAX)) begin
         return YEAR_MAX;
      end
      return YEAR_BITS'(sum);
   endfunction

endpackage

>>> hw/rtl/calendar_date_adjuster.sv
// Top level of the calendar date adjuster: stream ports, controller, datapath and result register.
//
// The block keeps a date (year, month, day, reset to January 1, 2018) and returns one result
// per item with the date after the item and a rejected flag for an invalid set of day or month.
// Items are handled one at a time. A set or an unknown op goes straight to the emit state, an add of
// days or years runs normalization first, and an add of months divides, applies and then normalizes.
// Normalization runs in the datapath's step unit: one step either removes four whole years
// (1461 days) or one month; once the year is within three of its maximum each month costs
// one step. A new item is taken as soon as the previous result sits in the output register.
module calendar_date_adjuster import cda_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // op [2:0], amount [18:3], zero [23:19]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // cur_year [15:0], cur_month [19:16], cur_day [24:20],
                                   // rejected [25], zero [31:26]
);

   ctrl_cmd_type         ctrl;
   dp_status_type        status;
   logic                 rsp_free;
   logic [YEAR_BITS-1:0] year;
   logic [MONTH_W-1:0]   month;
   logic [DAY_OUT_W-1:0] day;
   logic                 rejected;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff,  rsp_data_in;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tdata[OP_W-1:0]),
      .req_ready (req_tready),
      .rsp_free  (rsp_free),
      .status    (status),
      .ctrl      (ctrl)
   );

   cda_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .amount   (req_tdata[OP_W +: AMOUNT_W]),
      .status   (status),
      .year     (year),
      .month    (month),
      .day      (day),
      .rejected (rejected)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, rejected, day, month, CUR_YEAR_W'(year)};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/cda_ctrl.sv
// Controller state machine: sequences the datapath for one item at a time.
module cda_ctrl import cda_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic          req_ready,
   input  logic          rsp_free,
   input  dp_status_type status,
   output ctrl_cmd_type  ctrl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_APPLY,
      ST_NORM,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      ctrl.cmd  = CMD_NONE;
      ctrl.emit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EMIT;
               unique case (req_op)
                  OP_ADD_DAYS: begin
                     ctrl.cmd = CMD_ADD_DAYS;
                     state_in = ST_NORM;
                  end
                  OP_ADD_MONTHS: begin
                     ctrl.cmd = CMD_ADD_MONTHS;
                     state_in = ST_DIVIDE;
                  end
                  OP_ADD_YEARS: begin
                     ctrl.cmd = CMD_ADD_YEARS;
                     state_in = ST_NORM;
                  end
                  OP_SET_DAY:   ctrl.cmd = CMD_SET_DAY;
                  OP_SET_MONTH: ctrl.cmd = CMD_SET_MONTH;
                  OP_SET_YEAR:  ctrl.cmd = CMD_SET_YEAR;
                  default:      ctrl.cmd = CMD_IGNORE;
               endcase
            end
         end
         ST_DIVIDE: begin
            ctrl.cmd = CMD_DIVIDE;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            ctrl.cmd = CMD_APPLY_MONTHS;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (status.norm_done) begin
               state_in = ST_EMIT;
            end else begin
               ctrl.cmd = CMD_NORM_STEP;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               ctrl.emit = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/cda_dp.sv
// Datapath: date registers, divide-by-twelve for month adds and the normalization step.
module cda_dp import cda_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          ctrl,
   input  logic [AMOUNT_W-1:0]   amount,
   output dp_status_type         status,
   output logic [YEAR_BITS-1:0]  year,
   output logic [MONTH_W-1:0]    month,
   output logic [DAY_OUT_W-1:0]  day,
   output logic                  rejected
);

   logic [YEAR_BITS-1:0] year_ff,  year_in;
   logic [MONTH_W-1:0]   month_ff, month_in;
   logic [DAY_W-1:0]     day_ff,   day_in;
   logic                 rej_ff,   rej_in;
   logic [MSUM_W-1:0]    msum_ff,  msum_in;
   logic [QUOT_W-1:0]    quot_ff,  quot_in;

   logic [DAY_OUT_W-1:0]        lim;
   logic [DAY_OUT_W-1:0]        set_month_lim;
   logic                        can_quad;
   logic [MSUM_W+15:0]          product;
   logic [MSUM_W-1:0]           remainder;

   assign lim           = days_in(month_ff, year_ff[1:0]);
   assign set_month_lim = days_in(amount[MONTH_W-1:0], year_ff[1:0]);
   assign can_quad      = (day_ff > DAYS_PER_QUAD) &&
                          (year_ff <= YEAR_MAX - YEAR_BITS'(YEARS_PER_QUAD));
   assign product       = (MSUM_W+16)'(msum_ff) * (MSUM_W+16)'(RECIP_12);
   assign remainder     = msum_ff - MSUM_W'({quot_ff, 3'b000}) - MSUM_W'({quot_ff, 2'b00});

   assign status.norm_done = (day_ff <= DAY_W'(lim));

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      rej_in   = rej_ff;
      msum_in  = msum_ff;
      quot_in  = quot_ff;
      unique case (ctrl.cmd)
         CMD_ADD_DAYS: begin
            day_in = day_ff + DAY_W'(amount);
            rej_in = 1'b0;
         end
         CMD_ADD_MONTHS: begin
            msum_in = MSUM_W'(month_ff) - MSUM_W'(1) + MSUM_W'(amount);
            rej_in  = 1'b0;
         end
         CMD_ADD_YEARS: begin
            year_in = year_sat_add(year_ff, amount);
            rej_in  = 1'b0;
         end
         CMD_SET_DAY: begin
            if (amount == '0 || amount > AMOUNT_W'(lim)) begin
               rej_in = 1'b1;
            end else begin
               day_in = DAY_W'(amount);
               rej_in = 1'b0;
            end
         end
         CMD_SET_MONTH: begin
            if (amount == '0 || amount > AMOUNT_W'(MONTHS_PER_YEAR) ||
                day_ff > DAY_W'(set_month_lim)) begin
               rej_in = 1'b1;
            end else begin
               month_in = amount[MONTH_W-1:0];
               rej_in   = 1'b0;
            end
         end
         CMD_SET_YEAR: begin
            if (ADD_W'(amount) > ADD_W'(YEAR_MAX)) begin
               year_in = YEAR_MAX;
            end else begin
               year_in = YEAR_BITS'(amount);
            end
            rej_in = 1'b0;
         end
         CMD_IGNORE: begin
            rej_in = 1'b0;
         end
         CMD_DIVIDE: begin
            quot_in = QUOT_W'(product >> RECIP_SHIFT);
         end
         CMD_APPLY_MONTHS: begin
            year_in  = year_sat_add(year_ff, AMOUNT_W'(quot_ff));
            month_in = MONTH_W'(remainder) + MONTH_W'(1);
         end
         CMD_NORM_STEP: begin
            if (can_quad) begin
               // Skip four whole years at once; the month stays where it is.
               day_in  = day_ff - DAYS_PER_QUAD;
               year_in = year_ff + YEAR_BITS'(YEARS_PER_QUAD);
            end else begin
               day_in = day_ff - DAY_W'(lim);
               if (month_ff == MONTHS_PER_YEAR) begin
                  month_in = MONTH_W'(1);
                  year_in  = year_sat_add(year_ff, AMOUNT_W'(1));
               end else begin
                  month_in = month_ff + MONTH_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= YEAR_RESET;
         month_ff <= MONTH_W'(1);
         day_ff   <= DAY_W'(1);
         rej_ff   <= 1'b0;
      end else begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         rej_ff   <= rej_in;
      end
      msum_ff <= msum_in;
      quot_ff <= quot_in;
   end

   assign year     = year_ff;
   assign month    = month_ff;
   assign day      = day_ff[DAY_OUT_W-1:0];
   assign rejected = rej_ff;

endmodule

>>> test/calendar_date_adjuster_tb.sv
// Self-checking testbench for the calendar date adjuster: directed, stall and random date traffic.
module calendar_date_adjuster_tb import cda_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd6;
   localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd7;
   localparam int STALL_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES      = 100;
   localparam int RANDOM_ITEMS      = 640;
   localparam int STEADY_ITEMS      = 60;

   typedef struct packed {
      logic [CUR_YEAR_W-1:0] year;
      logic [MONTH_W-1:0]    month;
      logic [DAY_OUT_W-1:0]  day;
      logic                  rejected;
   } date_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // op [2:0], amount [18:3], zero [23:19]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // cur_year [15:0], cur_month [19:16], cur_day [24:20],
                             // rejected [25], zero [31:26]

   // Date as the testbench expects it after every item accepted so far.
   logic [YEAR_BITS-1:0] cal_year;
   logic [MONTH_W-1:0]   cal_month;
   int unsigned          cal_day;

   date_result_type pending_dates[$];
   int unsigned  error_count;
   int unsigned  result_count;
   int unsigned  slow_budget;
   logic         idle_enable;
   logic         long_hold_req;

   calendar_date_adjuster i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("status: fail");
      $finish;
   end

   function automatic int unsigned month_days(input logic [MONTH_W-1:0] m,
                                              input logic [YEAR_BITS-1:0] y);
      case (m)
         FEBRUARY: return (y[1:0] == 2'b00) ? 29 : 28;
         4'd4, 4'd6, 4'd9, 4'd11: return 30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
         default: return 0;
      endcase
   endfunction

   task automatic advance_year(input int unsigned n);
      if (n >= 32'(YEAR_MAX) - 32'(cal_year)) begin
         cal_year = YEAR_MAX;
      end else begin
         cal_year = cal_year + YEAR_BITS'(n);
      end
   endtask

   // Carries surplus days into the following months, and December into the next year.
   task automatic normalize_date();
      int unsigned lim;
      lim = month_days(cal_month, cal_year);
      while (lim != 0 && cal_day > lim) begin
         cal_day = cal_day - lim;
         cal_month = cal_month + MONTH_W'(1);
         if (cal_month > MONTHS_PER_YEAR) begin
            cal_month = 4'd1;
            advance_year(1);
         end
         lim = month_days(cal_month, cal_year);
      end
   endtask

   task automatic predict_date(input logic [OP_W-1:0] op, input logic [AMOUNT_W-1:0] amount);
      date_result_type want;
      int unsigned  m;
      want.rejected = 1'b0;
      case (op)
         OP_ADD_DAYS: begin
            cal_day = cal_day + 32'(amount);
            normalize_date();
         end
         OP_ADD_MONTHS: begin
            m = 32'(cal_month) + 32'(amount) - 1;
            advance_year(m / 12);
            cal_month = MONTH_W'(m % 12 + 1);
            normalize_date();
         end
         OP_ADD_YEARS: begin
            advance_year(32'(amount));
            normalize_date();
         end
         OP_SET_DAY: begin
            if (amount == '0 || 32'(amount) > month_days(cal_month, cal_year)) begin
               want.rejected = 1'b1;
            end else begin
               cal_day = 32'(amount);
            end
         end
         OP_SET_MONTH: begin
            if (amount == '0 || amount > AMOUNT_W'(MONTHS_PER_YEAR) ||
                cal_day > month_days(MONTH_W'(amount), cal_year)) begin
               want.rejected = 1'b1;
            end else begin
               cal_month = MONTH_W'(amount);
            end
         end
         OP_SET_YEAR: begin
            cal_year = amount;
         end
         default: begin
         end
      endcase
      want.year  = cal_year;
      want.month = cal_month;
      want.day   = DAY_OUT_W'(cal_day);
      pending_dates.push_back(want);
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch at result %0d: %s got %0d expected %0d", result_count, what, got,
               want);
      error_count++;
   endtask

   // Called and returns at a falling edge; the expectation is formed at the transfer.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [AMOUNT_W-1:0] amount);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, amount, op};
      do @(posedge clock); while (!req_tready);
      predict_date(op, amount);
      @(negedge clock);
   endtask

   // Receiver side: random hold-off bursts, and one long hold on request.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (STALL_HOLD_CYCLES - 1) @(negedge clock);
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            rsp_tready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      date_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_dates.size() == 0) begin
            report_mismatch("result with nothing pending, year", 32'(rsp_tdata[15:0]), 0);
         end else begin
            want = pending_dates.pop_front();
            if (rsp_tdata[15:0] != want.year) begin
               report_mismatch("cur_year", 32'(rsp_tdata[15:0]), 32'(want.year));
            end
            if (rsp_tdata[19:16] != want.month) begin
               report_mismatch("cur_month", 32'(rsp_tdata[19:16]), 32'(want.month));
            end
            if (rsp_tdata[24:20] != want.day) begin
               report_mismatch("cur_day", 32'(rsp_tdata[24:20]), 32'(want.day));
            end
            if (rsp_tdata[25] != want.rejected) begin
               report_mismatch("rejected", 32'(rsp_tdata[25]), 32'(want.rejected));
            end
         end
         result_count++;
      end
   end

   task automatic test_set_checks();
      send_item(OP_SET_DAY, 16'd0);
      send_item(OP_SET_DAY, 16'd31);
      send_item(OP_SET_DAY, 16'd32);
      send_item(OP_SET_DAY, 16'hFFFF);
      send_item(OP_SET_MONTH, 16'd0);
      send_item(OP_SET_MONTH, 16'd13);
      send_item(OP_SET_MONTH, 16'hFFFF);
      // Day 31 does not fit February, so the move is refused.
      send_item(OP_SET_MONTH, 16'd2);
      send_item(OP_SET_DAY, 16'd1);
      send_item(OP_SET_MONTH, 16'd2);
      send_item(OP_SET_DAY, 16'd29);
      send_item(OP_SET_YEAR, 16'd2020);
      send_item(OP_SET_DAY, 16'd29);
      // February 29 in a common year stays as it is until the next add.
      send_item(OP_SET_YEAR, 16'd2019);
      send_item(OP_ADD_DAYS, 16'd0);
      send_item(OP_RESERVED_A, 16'hFFFF);
      send_item(OP_RESERVED_B, 16'd0);
   endtask

   task automatic test_add_carries();
      send_item(OP_ADD_DAYS, 16'hFFFF);
      send_item(OP_ADD_MONTHS, 16'hFFFF);
      send_item(OP_ADD_YEARS, 16'd0);
      send_item(OP_SET_YEAR, 16'hFFFF);
      send_item(OP_SET_DAY, 16'd1);
      send_item(OP_SET_MONTH, 16'd12);
      send_item(OP_SET_DAY, 16'd31);
      // Carry out of December at the top year wraps the month only.
      send_item(OP_ADD_DAYS, 16'd1);
      send_item(OP_ADD_YEARS, 16'hFFFF);
      send_item(OP_ADD_MONTHS, 16'hFFFF);
      send_item(OP_ADD_DAYS, 16'd4000);
      send_item(OP_SET_YEAR, 16'd0);
   endtask

   task automatic test_output_stall();
      long_hold_req = 1'b1;
      repeat (12) begin
         send_item(OP_ADD_DAYS, 16'($urandom_range(0, 40)));
      end
   endtask

   task automatic send_random_item();
      logic [OP_W-1:0]     op;
      logic [AMOUNT_W-1:0] amount;
      int unsigned         pick;
      int unsigned         shape;
      pick  = $urandom_range(0, 99);
      shape = $urandom_range(0, 9);
      amount = 16'($urandom());
      if (pick < 28) begin
         op = OP_ADD_DAYS;
         if (shape < 6) begin
            amount = 16'($urandom_range(0, 60));
         end else if (shape < 9) begin
            amount = 16'($urandom_range(0, 2000));
         end
         // Near the top year every month is a separate step, so long adds are kept rare.
         if (cal_year > YEAR_MAX - 16'd8 && amount > 16'd1023) begin
            if (slow_budget == 0) begin
               amount = AMOUNT_W'(amount[9:0]);
            end else begin
               slow_budget--;
            end
         end
      end else if (pick < 42) begin
         op = OP_ADD_MONTHS;
         if (shape < 7) begin
            amount = 16'($urandom_range(0, 30));
         end else if (shape < 9) begin
            amount = 16'($urandom_range(0, 600));
         end
      end else if (pick < 52) begin
         op = OP_ADD_YEARS;
         if (shape < 8) begin
            amount = 16'($urandom_range(0, 10));
         end else if (shape < 9) begin
            amount = 16'($urandom_range(0, 300));
         end
      end else if (pick < 70) begin
         op = OP_SET_DAY;
         if (shape < 7) begin
            amount = 16'($urandom_range(1, month_days(cal_month, cal_year)));
         end else if (shape < 9) begin
            amount = 16'($urandom_range(0, 40));
         end
      end else if (pick < 84) begin
         op = OP_SET_MONTH;
         if (shape < 7) begin
            amount = 16'($urandom_range(1, 12));
         end else if (shape < 9) begin
            amount = 16'($urandom_range(0, 20));
         end
      end else if (pick < 96) begin
         op = OP_SET_YEAR;
         if (shape < 6) begin
            amount = 16'($urandom_range(1900, 2100));
         end else if (shape < 8) begin
            amount = 16'($urandom_range(0, 9999));
         end else if (shape < 9) begin
            amount = 16'($urandom_range(65530, 65535));
         end
      end else begin
         op = (shape < 5) ? OP_RESERVED_A : OP_RESERVED_B;
      end
      send_item(op, amount);
   endtask

   task automatic test_random_traffic(input int unsigned count, input logic with_idle);
      idle_enable = with_idle;
      repeat (count) begin
         send_random_item();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      idle_enable   = 1'b1;
      long_hold_req = 1'b0;
      error_count   = 0;
      result_count  = 0;
      slow_budget   = 6;
      cal_year      = YEAR_RESET;
      cal_month     = 4'd1;
      cal_day       = 1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_set_checks();
      test_add_carries();
      test_output_stall();
      test_random_traffic(RANDOM_ITEMS, 1'b1);
      test_random_traffic(STEADY_ITEMS, 1'b0);

      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
